// ----- sv/m2p_pkg.sv -----
// Shared types, codes and the note period table for the MIDI to PSG register writer.
package m2p_pkg;

  localparam int MAX_WR      = 4;
  localparam int WR_IDX_W    = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_CC       = 2'd2;
  localparam logic [1:0] KIND_INIT     = 2'd3;

  localparam logic [6:0] CC_NOISE    = 7'd1;
  localparam logic [6:0] CC_CHAN_VOL = 7'd7;
  localparam logic [6:0] CC_ALL_OFF  = 7'd123;

  localparam logic [3:0] REG_MIXER    = 4'd7;
  localparam logic [3:0] REG_VOL_BASE = 4'd8;

  // Mixer bits are active low: bit v tone off, bit v+3 noise off.
  localparam logic [5:0] MIXER_ALL_OFF = 6'h3F;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
  } wr_t;

  // One decoded event: up to four writes, last_idx is the index of the final one.
  typedef struct packed {
    wr_t [MAX_WR-1:0]    wr;
    logic [WR_IDX_W-1:0] last_idx;
  } cmd_t;

  // Tone period per note number; zero marks a note that is not played.
  localparam logic [11:0] PERIOD_TABLE [128] = '{
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd0,    12'd0,    12'd0,    12'd0,    12'd0,    12'd4067, 12'd3838, 12'd3623,
    12'd3419, 12'd3228, 12'd3046, 12'd2875, 12'd2714, 12'd2561, 12'd2418, 12'd2282,
    12'd2154, 12'd2033, 12'd1919, 12'd1811, 12'd1709, 12'd1613, 12'd1523, 12'd1437,
    12'd1356, 12'd1280, 12'd1208, 12'd1140, 12'd1076, 12'd1016, 12'd959,  12'd905,
    12'd854,  12'd806,  12'd761,  12'd718,  12'd678,  12'd640,  12'd604,  12'd570,
    12'd538,  12'd507,  12'd479,  12'd452,  12'd427,  12'd403,  12'd380,  12'd359,
    12'd338,  12'd319,  12'd301,  12'd284,  12'd268,  12'd253,  12'd239,  12'd225,
    12'd213,  12'd201,  12'd189,  12'd179,  12'd169,  12'd159,  12'd150,  12'd142,
    12'd134,  12'd126,  12'd119,  12'd112,  12'd106,  12'd100,  12'd94,   12'd89,
    12'd84,   12'd79,   12'd75,   12'd70,   12'd66,   12'd63,   12'd59,   12'd56,
    12'd52,   12'd49,   12'd47,   12'd44,   12'd41,   12'd39,   12'd37,   12'd35,
    12'd33,   12'd31,   12'd29,   12'd27,   12'd26,   12'd24,   12'd23,   12'd21,
    12'd20,   12'd19,   12'd18,   12'd17,   12'd16,   12'd15,   12'd14,   12'd13,
    12'd12,   12'd12,   12'd11,   12'd10,   12'd10,   12'd9,    12'd8,    12'd8
  };

endpackage

// ----- sv/m2p_in_if.sv -----
// Event channel: valid/ready handshake with the MIDI-style event fields.
interface m2p_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] channel;
  logic [6:0] note;
  logic [6:0] velocity;
  logic [6:0] controller;
  logic [6:0] control_value;

  modport source (output valid, kind, channel, note, velocity, controller, control_value,
                  input ready);
  modport sink   (input valid, kind, channel, note, velocity, controller, control_value,
                  output ready);
endinterface

// ----- sv/m2p_out_if.sv -----
// Register write channel: valid/ready handshake with address, data and last flag.
interface m2p_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_addr;
  logic [7:0] reg_data;
  logic       last;

  modport source (output valid, reg_addr, reg_data, last, input ready);
  modport sink   (input valid, reg_addr, reg_data, last, output ready);
endinterface

// ----- sv/m2p_front.sv -----
// Front end: accepts events, updates voice and mixer state, builds the write list.
module m2p_front #(
  parameter int VOICES = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  m2p_in_if.sink        in_evt,
  output logic          push_valid,
  output m2p_pkg::cmd_t push_cmd,
  input  logic          push_ready
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [VOICES-1:0] act_r, act_nxt;
  logic [5:0]        mix_r, mix_nxt;

  logic              accept;
  logic              ch_ok;
  logic [VIDX_W-1:0] ch_idx;
  logic [5:0]        tone_m, noise_m;
  logic [3:0]        vol_addr, plo_addr;
  logic [11:0]       period;

  assign in_evt.ready = push_ready;
  assign accept   = in_evt.valid && push_ready;
  assign ch_ok    = in_evt.channel < 4'(VOICES);
  assign ch_idx   = in_evt.channel[VIDX_W-1:0];
  assign tone_m   = 6'd1 << ch_idx;
  assign noise_m  = 6'd8 << ch_idx;
  assign vol_addr = m2p_pkg::REG_VOL_BASE + 4'(ch_idx);
  assign plo_addr = 4'(ch_idx) << 1;
  assign period   = m2p_pkg::PERIOD_TABLE[in_evt.note];

  always_comb begin
    logic [5:0] m;
    m          = mix_r;
    act_nxt    = act_r;
    mix_nxt    = mix_r;
    push_cmd   = '0;
    push_valid = 1'b0;
    if (accept) begin
      if (in_evt.kind == m2p_pkg::KIND_INIT) begin
        mix_nxt = m2p_pkg::MIXER_ALL_OFF;
        act_nxt = '0;
        push_cmd.wr[0].reg_addr = m2p_pkg::REG_MIXER;
        push_cmd.wr[0].reg_data = 8'(m2p_pkg::MIXER_ALL_OFF);
        for (int v = 0; v < VOICES; v++) begin
          push_cmd.wr[v+1].reg_addr = m2p_pkg::REG_VOL_BASE + 4'(v);
          push_cmd.wr[v+1].reg_data = 8'd0;
        end
        push_cmd.last_idx = VOICES[m2p_pkg::WR_IDX_W-1:0];
        push_valid = 1'b1;
      end else if (ch_ok) begin
        if (in_evt.kind == m2p_pkg::KIND_NOTE_ON) begin
          if (period != 12'd0) begin
            m = (mix_r & ~tone_m) | noise_m;
            mix_nxt = m;
            act_nxt[ch_idx] = 1'b1;
            push_cmd.wr[0].reg_addr = plo_addr;
            push_cmd.wr[0].reg_data = period[7:0];
            push_cmd.wr[1].reg_addr = plo_addr | 4'd1;
            push_cmd.wr[1].reg_data = {4'd0, period[11:8]};
            push_cmd.wr[2].reg_addr = vol_addr;
            push_cmd.wr[2].reg_data = {4'd0, in_evt.velocity[6:3]};
            push_cmd.wr[3].reg_addr = m2p_pkg::REG_MIXER;
            push_cmd.wr[3].reg_data = {2'd0, m};
            push_cmd.last_idx = 2'd3;
            push_valid = 1'b1;
          end
        end else if (in_evt.kind == m2p_pkg::KIND_NOTE_OFF ||
                     (in_evt.kind == m2p_pkg::KIND_CC &&
                      in_evt.controller == m2p_pkg::CC_ALL_OFF)) begin
          act_nxt[ch_idx] = 1'b0;
          push_cmd.wr[0].reg_addr = vol_addr;
          push_cmd.wr[0].reg_data = 8'd0;
          push_valid = 1'b1;
        end else if (in_evt.controller == m2p_pkg::CC_NOISE) begin
          // value >= 64 turns noise on (active-low bit cleared)
          m = in_evt.control_value[6] ? (mix_r & ~noise_m) : (mix_r | noise_m);
          mix_nxt = m;
          push_cmd.wr[0].reg_addr = m2p_pkg::REG_MIXER;
          push_cmd.wr[0].reg_data = {2'd0, m};
          push_valid = 1'b1;
        end else if (in_evt.controller == m2p_pkg::CC_CHAN_VOL) begin
          // new volume goes straight out, and only while the voice is sounding
          if (act_r[ch_idx]) begin
            push_cmd.wr[0].reg_addr = vol_addr;
            push_cmd.wr[0].reg_data = {4'd0, in_evt.control_value[6:3]};
            push_valid = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      mix_r <= m2p_pkg::MIXER_ALL_OFF;
    end else begin
      act_r <= act_nxt;
      mix_r <= mix_nxt;
    end
  end

endmodule

// ----- sv/m2p_queue.sv -----
// Short command queue between the front end and the write sequencer.
module m2p_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  m2p_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output m2p_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);

  m2p_pkg::cmd_t q_mem [m2p_pkg::QUEUE_DEPTH];

  logic [m2p_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [m2p_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign push_ready = cnt_r != (m2p_pkg::QPTR_W+1)'(m2p_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = q_mem[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wp_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/m2p_back.sv -----
// Back end: moves a command's writes to the output register, one per unstalled cycle.
module m2p_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  m2p_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  m2p_out_if.source     out_wr
);

  m2p_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [m2p_pkg::WR_IDX_W-1:0] idx_r, idx_nxt;
  logic                         busy_r, busy_nxt;
  logic                         ov_r, ov_nxt;
  logic [3:0]                   oa_r, oa_nxt;
  logic [7:0]                   od_r, od_nxt;
  logic                         ol_r, ol_nxt;

  logic adv, at_last;

  assign adv       = !ov_r || out_wr.ready;
  assign at_last   = idx_r == cmd_r.last_idx;
  // next command may load in the same cycle its predecessor's last write is registered
  assign pop_ready = !busy_r || (adv && at_last);

  assign out_wr.valid    = ov_r;
  assign out_wr.reg_addr = oa_r;
  assign out_wr.reg_data = od_r;
  assign out_wr.last     = ol_r;

  always_comb begin
    cmd_nxt  = cmd_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    oa_nxt   = oa_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    if (adv) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        oa_nxt   = cmd_r.wr[idx_r].reg_addr;
        od_nxt   = cmd_r.wr[idx_r].reg_data;
        ol_nxt   = at_last;
        idx_nxt  = idx_r + 1'b1;
        busy_nxt = !at_last;
      end
    end
    if (pop_valid && pop_ready) begin
      cmd_nxt  = pop_cmd;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    oa_r  <= oa_nxt;
    od_r  <= od_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

// ----- sv/midi_to_psg_register_writer_unit.sv -----
// Top level of the MIDI to PSG register writer.
// Turns note on, note off, control change and initialise events into register
// writes for a three-channel tone generator. The front end takes one event per
// cycle while the command queue has room, updates the per-voice active flags and
// the mixer shadow, and queues the event's write list (zero to four writes; events
// that cause none are dropped there). The back end sends one write per cycle,
// unless the output stalls, through a registered output, with last set on the
// final write of each event. Each event holds the output for all its writes, four
// for note on, so the sustained rate is set by the write sequencer. A four-entry
// command queue lets events be accepted while earlier writes stall at the output.
module midi_to_psg_register_writer_unit #(
  parameter int VOICES = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  m2p_in_if.sink    in_evt,
  m2p_out_if.source out_wr
);

  logic          push_valid, push_ready;
  m2p_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  m2p_pkg::cmd_t pop_cmd;

  m2p_front #(
    .VOICES(VOICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_evt    (in_evt),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready)
  );

  m2p_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready)
  );

  m2p_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_cmd  (pop_cmd),
    .pop_ready(pop_ready),
    .out_wr   (out_wr)
  );

endmodule

// ----- tb/sv/psg_write_checker.sv -----
// Watches the event and register write channels, predicts the write stream and scores it.
module psg_write_checker
  import m2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  m2p_in_if           evt,
  m2p_out_if          wr,
  output int unsigned fail_count,
  output int unsigned writes_due,
  output int unsigned writes_checked
);

  localparam int NUM_VOICES = 3;

  typedef struct packed {
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } psg_write_t;

  // Tone period per note; zero means the note is not played.
  localparam int NOTE_PERIOD [128] = '{
       0,    0,    0,    0,    0,    0,    0,    0,
       0,    0,    0,    0,    0,    0,    0,    0,
       0,    0,    0,    0,    0, 4067, 3838, 3623,
    3419, 3228, 3046, 2875, 2714, 2561, 2418, 2282,
    2154, 2033, 1919, 1811, 1709, 1613, 1523, 1437,
    1356, 1280, 1208, 1140, 1076, 1016,  959,  905,
     854,  806,  761,  718,  678,  640,  604,  570,
     538,  507,  479,  452,  427,  403,  380,  359,
     338,  319,  301,  284,  268,  253,  239,  225,
     213,  201,  189,  179,  169,  159,  150,  142,
     134,  126,  119,  112,  106,  100,   94,   89,
      84,   79,   75,   70,   66,   63,   59,   56,
      52,   49,   47,   44,   41,   39,   37,   35,
      33,   31,   29,   27,   26,   24,   23,   21,
      20,   19,   18,   17,   16,   15,   14,   13,
      12,   12,   11,   10,   10,    9,    8,    8
  };

  psg_write_t psg_writes_pending [$];
  logic [3:0] voice_vol [NUM_VOICES];
  logic       voice_on  [NUM_VOICES];
  logic [5:0] mixer_bits;

  function automatic void add_write(input logic [3:0] addr, input logic [7:0] data);
    psg_writes_pending.push_back('{addr, data, 1'b0});
  endfunction

  function automatic void predict_psg_writes(input logic [1:0] kind, input logic [3:0] chan,
                                             input logic [6:0] note, input logic [6:0] vel,
                                             input logic [6:0] cc, input logic [6:0] val);
    int          v;
    int          i;
    int unsigned depth_before;
    logic [11:0] period;
    v            = int'(chan);
    depth_before = psg_writes_pending.size();
    if (kind == KIND_INIT) begin
      mixer_bits = MIXER_ALL_OFF;
      add_write(REG_MIXER, {2'b00, mixer_bits});
      for (i = 0; i < NUM_VOICES; i++) begin
        voice_vol[i] = 4'd15;
        voice_on[i]  = 1'b0;
        add_write(4'(REG_VOL_BASE + i), 8'd0);
      end
    end else if (v < NUM_VOICES) begin
      if (kind == KIND_NOTE_ON) begin
        period = 12'(NOTE_PERIOD[note]);
        if (period != 12'd0) begin
          voice_vol[v]      = vel[6:3];
          voice_on[v]       = 1'b1;
          mixer_bits[v]     = 1'b0;
          mixer_bits[v + 3] = 1'b1;
          add_write(4'(2 * v), period[7:0]);
          add_write(4'(2 * v + 1), {4'd0, period[11:8]});
          add_write(4'(REG_VOL_BASE + v), {4'd0, voice_vol[v]});
          add_write(REG_MIXER, {2'b00, mixer_bits});
        end
      end else if (kind == KIND_NOTE_OFF || cc == CC_ALL_OFF) begin
        voice_on[v] = 1'b0;
        add_write(4'(REG_VOL_BASE + v), 8'd0);
      end else if (cc == CC_NOISE) begin
        // noise-off bit is active low
        mixer_bits[v + 3] = (val < 7'd64);
        add_write(REG_MIXER, {2'b00, mixer_bits});
      end else if (cc == CC_CHAN_VOL) begin
        voice_vol[v] = val[6:3];
        if (voice_on[v])
          add_write(4'(REG_VOL_BASE + v), {4'd0, voice_vol[v]});
      end
    end
    if (psg_writes_pending.size() > depth_before)
      psg_writes_pending[psg_writes_pending.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : score
    psg_write_t want;
    int         i;
    if (!rst_n) begin
      for (i = 0; i < NUM_VOICES; i++) begin
        voice_vol[i] = 4'd15;
        voice_on[i]  = 1'b0;
      end
      mixer_bits = MIXER_ALL_OFF;
      psg_writes_pending.delete();
      fail_count     = 0;
      writes_checked = 0;
    end else begin
      // predict first so a same-cycle pass-through would still line up
      if (evt.valid && evt.ready)
        predict_psg_writes(evt.kind, evt.channel, evt.note, evt.velocity, evt.controller,
                           evt.control_value);
      if (wr.valid && wr.ready) begin
        if (psg_writes_pending.size() == 0) begin
          $display("%0t: unexpected write: expected none, got addr=%0d data=0x%02h last=%0b",
                   $time, wr.reg_addr, wr.reg_data, wr.last);
          fail_count++;
        end else begin
          want = psg_writes_pending.pop_front();
          writes_checked++;
          if (wr.reg_addr !== want.addr) begin
            $display("%0t: reg_addr mismatch: expected %0d, got %0d", $time, want.addr,
                     wr.reg_addr);
            fail_count++;
          end
          if (wr.reg_data !== want.data) begin
            $display("%0t: reg_data mismatch (addr %0d): expected 0x%02h, got 0x%02h", $time,
                     want.addr, want.data, wr.reg_data);
            fail_count++;
          end
          if (wr.last !== want.last) begin
            $display("%0t: last mismatch (addr %0d): expected %0b, got %0b", $time, want.addr,
                     want.last, wr.last);
            fail_count++;
          end
        end
      end
    end
    writes_due = psg_writes_pending.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the register writer bench: clock, reset, event stimulus, output back-pressure, verdict.
module tb;
  import m2p_pkg::*;

  localparam int RANDOM_EVENTS = 300;
  localparam int HOLD_CYCLES   = 80;
  localparam int CYCLE_LIMIT   = 300000;

  logic        clk;
  logic        rst_n;
  logic        hold_req;
  logic        quiet;
  int unsigned fail_count;
  int unsigned writes_due;
  int unsigned writes_checked;
  int unsigned cycle_count = 0;
  int unsigned events_sent;
  int unsigned holds_done;

  m2p_in_if  evt_if ();
  m2p_out_if wr_if ();

  midi_to_psg_register_writer_unit #(.VOICES(3)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_evt (evt_if),
    .out_wr (wr_if)
  );

  psg_write_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt            (evt_if),
    .wr             (wr_if),
    .fail_count     (fail_count),
    .writes_due     (writes_due),
    .writes_checked (writes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d writes outstanding", $time, writes_due);
      $display("midi_to_psg_register_writer_unit verification failed");
      $finish;
    end
  end

  // Write sink: random stall bursts, one long hold-off on request, none once quiet.
  initial begin : write_sink
    int stall_cnt;
    wr_if.ready = 1'b0;
    holds_done  = 0;
    forever begin
      @(negedge clk);
      if (hold_req && holds_done == 0) begin
        wr_if.ready <= 1'b0;
        stall_cnt = 0;
        while (stall_cnt < HOLD_CYCLES) begin
          @(negedge clk);
          stall_cnt++;
        end
        holds_done++;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        wr_if.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        wr_if.ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_event(input logic [1:0] kind, input logic [3:0] chan,
                            input logic [6:0] note, input logic [6:0] vel,
                            input logic [6:0] cc, input logic [6:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    evt_if.valid         <= 1'b1;
    evt_if.kind          <= kind;
    evt_if.channel       <= chan;
    evt_if.note          <= note;
    evt_if.velocity      <= vel;
    evt_if.controller    <= cc;
    evt_if.control_value <= val;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  // Mostly well-formed events on live voices; some unlisted notes, dead voices, odd controllers.
  task automatic send_random_event(output bit effective);
    logic [1:0] kind;
    logic [3:0] chan;
    logic [6:0] note;
    logic [6:0] cc;
    int         pick;
    pick = $urandom_range(0, 99);
    kind = (pick < 45) ? KIND_NOTE_ON : (pick < 62) ? KIND_NOTE_OFF :
           (pick < 95) ? KIND_CC : KIND_INIT;
    chan = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(3, 15)) : 4'($urandom_range(0, 2));
    note = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 20)) : 7'($urandom_range(21, 127));
    pick = $urandom_range(0, 9);
    cc   = (pick < 3) ? CC_NOISE : (pick < 6) ? CC_CHAN_VOL : (pick < 8) ? CC_ALL_OFF :
           7'($urandom);
    effective = (kind == KIND_INIT) ||
                (chan < 4'd3 && (kind != KIND_NOTE_ON || note >= 7'd21) &&
                 (kind != KIND_CC || cc inside {CC_NOISE, CC_CHAN_VOL, CC_ALL_OFF}));
    send_event(kind, chan, note, 7'($urandom), cc, 7'($urandom));
  endtask

  initial begin : stimulus
    int unsigned effective_cnt;
    bit          hit;
    bit          stall_issued;
    bit          drain_done;
    rst_n                = 1'b0;
    hold_req             = 1'b0;
    quiet                = 1'b0;
    events_sent          = 0;
    evt_if.valid         = 1'b0;
    evt_if.kind          = KIND_INIT;
    evt_if.channel       = 4'd0;
    evt_if.note          = 7'd0;
    evt_if.velocity      = 7'd0;
    evt_if.controller    = 7'd0;
    evt_if.control_value = 7'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every kind, table edges, dead voices, controller thresholds
    send_event(KIND_INIT,     4'd9,  7'd0,   7'd0,   7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd0,  7'd21,  7'd127, 7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd1,  7'd127, 7'd0,   7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd2,  7'd20,  7'd127, 7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd2,  7'd0,   7'd127, 7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd2,  7'd60,  7'd64,  7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd3,  7'd60,  7'd100, 7'd0,        7'd0);
    send_event(KIND_NOTE_ON,  4'd15, 7'd127, 7'd127, 7'd0,        7'd0);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   CC_NOISE,    7'd127);
    send_event(KIND_CC,       4'd1,  7'd0,   7'd0,   CC_NOISE,    7'd64);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   CC_NOISE,    7'd63);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   CC_CHAN_VOL, 7'd127);
    send_event(KIND_NOTE_OFF, 4'd1,  7'd0,   7'd0,   7'd0,        7'd0);
    send_event(KIND_CC,       4'd1,  7'd0,   7'd0,   CC_CHAN_VOL, 7'd0);
    send_event(KIND_CC,       4'd2,  7'd0,   7'd0,   CC_ALL_OFF,  7'd0);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   7'd0,        7'd127);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   7'd127,      7'd127);
    send_event(KIND_NOTE_OFF, 4'd15, 7'd0,   7'd0,   7'd0,        7'd0);
    send_event(KIND_NOTE_OFF, 4'd2,  7'd0,   7'd0,   7'd0,        7'd0);
    send_event(KIND_CC,       4'd3,  7'd0,   7'd0,   CC_CHAN_VOL, 7'd127);
    send_event(KIND_CC,       4'd12, 7'd0,   7'd0,   CC_NOISE,    7'd127);
    send_event(KIND_INIT,     4'd0,  7'd127, 7'd127, 7'd127,      7'd127);
    send_event(KIND_NOTE_ON,  4'd0,  7'd108, 7'd8,   7'd0,        7'd0);
    send_event(KIND_CC,       4'd0,  7'd0,   7'd0,   CC_CHAN_VOL, 7'd7);

    effective_cnt = 0;
    stall_issued  = 1'b0;
    drain_done    = 1'b0;
    while (effective_cnt < RANDOM_EVENTS) begin
      if (effective_cnt >= 75 && !stall_issued) begin
        // sink freezes while events keep coming, so the command queue backs up
        hold_req <= 1'b1;
        stall_issued = 1'b1;
      end
      if (effective_cnt >= 165 && !drain_done) begin
        evt_if.valid <= 1'b0;
        wait (writes_due == 0);
        @(negedge clk);
        drain_done = 1'b1;
      end
      if (effective_cnt >= 240)
        quiet <= 1'b1;
      send_random_event(hit);
      if (hit)
        effective_cnt++;
    end
    evt_if.valid <= 1'b0;

    wait (writes_due == 0);
    repeat (20) @(negedge clk);
    $display("tb: %0d events sent, %0d register writes checked, %0d long sink hold-offs",
             events_sent, writes_checked, holds_done);
    $display("tb: covered every event kind, table edges, dead voices and an idle drain pause");
    if (fail_count == 0 && writes_due == 0) begin
      $display("midi_to_psg_register_writer_unit verification clean");
    end else begin
      $display("midi_to_psg_register_writer_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/m2p_pkg.sv
sv/m2p_in_if.sv
sv/m2p_out_if.sv
sv/m2p_front.sv
sv/m2p_queue.sv
sv/m2p_back.sv
sv/midi_to_psg_register_writer_unit.sv
tb/sv/psg_write_checker.sv
tb/sv/tb.sv
